// File: hw/rtl/seven_segment_number_formatter_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the seven-segment number formatter
// Same-cycle and next-cycle implication checks on the block clock.
// ----------------------------------------------------------------------------
`ifndef SEVEN_SEGMENT_NUMBER_FORMATTER_ASSERT_SVH
`define SEVEN_SEGMENT_NUMBER_FORMATTER_ASSERT_SVH

// Check that cons holds in the same cycle as ante
`define SSNF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Check that cons holds in the cycle after ante
`define SSNF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/ssnf_pkg.sv
// ----------------------------------------------------------------------------
// ssnf_pkg
// Shared codes, cell control type and segment decode for the formatter.
// ----------------------------------------------------------------------------
package ssnf_pkg;

    // Request opcodes
    localparam logic [1:0] OP_AUTO   = 2'd0;
    localparam logic [1:0] OP_FIXED  = 2'd1;
    localparam logic [1:0] OP_SIGNED = 2'd2;

    // Radix codes on the request
    localparam logic [1:0] RADIX_BIN = 2'd0;
    localparam logic [1:0] RADIX_DEC = 2'd1;

    localparam logic [7:0] SEG_DASH = 8'h40;

    // Conversion behavior of one digit cell
    typedef enum logic [1:0] {
        CELL_BIN,
        CELL_DEC,
        CELL_HEX
    } t_cell_mode;

    // Control bundle driven to every cell of the chain
    typedef struct packed {
        logic       clear;
        logic       shift;
        t_cell_mode mode;
    } t_cell_ctrl;

    // Segment pattern of a hex digit, bit0 = a ... bit6 = g
    function automatic logic [7:0] seg_of(input logic [3:0] digit);
        logic [7:0] seg;
        case (digit)
            4'h0: seg = 8'h3F;
            4'h1: seg = 8'h06;
            4'h2: seg = 8'h5B;
            4'h3: seg = 8'h4F;
            4'h4: seg = 8'h66;
            4'h5: seg = 8'h6D;
            4'h6: seg = 8'h7D;
            4'h7: seg = 8'h07;
            4'h8: seg = 8'h7F;
            4'h9: seg = 8'h6F;
            4'hA: seg = 8'h77;
            4'hB: seg = 8'h7C;
            4'hC: seg = 8'h39;
            4'hD: seg = 8'h5E;
            4'hE: seg = 8'h79;
            default: seg = 8'h71;
        endcase
        return seg;
    endfunction

endpackage

// File: hw/rtl/seven_segment_number_formatter.sv
// ----------------------------------------------------------------------------
// seven_segment_number_formatter
// Converts a number to up to NUM_DIGITS seven-segment digits, one per result.
// ----------------------------------------------------------------------------
// Sequence: the value is shifted bit-serially through the digit chain, then the
// length state counts the digits to show and the output register gives one result
// per cycle, up to NUM_DIGITS in all; a negative value with fewer digits than
// NUM_DIGITS adds a dash. A new request is taken only in idle, after the last
// result, so a request cannot start before the previous one is through.
// Results cannot be stalled. Synchronous active-low reset returns to idle.
module seven_segment_number_formatter
    import ssnf_pkg::*;
#(
    parameter int NUM_DIGITS  = 6,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [1:0]             i_opcode,
    input  logic [VALUE_WIDTH-1:0] i_value,
    input  logic [1:0]             i_radix,
    input  logic                   i_left_align,
    input  logic [2:0]             i_digit_count,
    output logic                   o_strobe,
    output logic [7:0]             o_segments,
    output logic [NUM_DIGITS-1:0]  o_digit_select,
    output logic                   o_last
);

    localparam int CW = $clog2(NUM_DIGITS + 1);
    localparam int IW = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
    localparam int BW = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;
    localparam logic [CW-1:0] NDIG = CW'(NUM_DIGITS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_LEN,
        ST_EMIT
    } t_state;

    t_state                 r_state;
    logic [VALUE_WIDTH-1:0] r_shreg;
    logic [BW-1:0]          r_bitcnt;
    logic                   r_ovf;
    t_cell_mode             r_mode;
    logic                   r_fixed;
    logic                   r_left;
    logic                   r_neg;
    logic [2:0]             r_cnt;
    logic [CW-1:0]          r_len;
    logic [IW-1:0]          r_dig;
    logic                   r_dash;
    logic                   r_dash_now;
    logic                   r_strobe;
    logic [7:0]             r_seg;
    logic [NUM_DIGITS-1:0]  r_sel;
    logic                   r_last;

    t_cell_ctrl             w_ctrl;
    logic [NUM_DIGITS:0]    w_carry;
    logic [3:0]             w_digit [NUM_DIGITS];
    logic                   w_accept;
    logic [VALUE_WIDTH-1:0] w_mag;
    logic [CW-1:0]          w_len;
    logic [CW-1:0]          w_pos;

    assign w_accept = start && (r_state == ST_IDLE);
    assign busy     = (r_state != ST_IDLE);

    // Take the magnitude of a negative signed request
    assign w_mag = ((i_opcode == OP_SIGNED) && i_value[VALUE_WIDTH-1]) ?
                   (~i_value + VALUE_WIDTH'(1)) : i_value;

    // Drive the shared cell controls
    always_comb begin
        w_ctrl.clear = w_accept;
        w_ctrl.shift = (r_state == ST_CONV);
        w_ctrl.mode  = r_mode;
    end

    // Chain of digit cells, least significant first
    assign w_carry[0] = r_shreg[VALUE_WIDTH-1];
    for (genvar g = 0; g < NUM_DIGITS; g++) begin : g_cell
        ssnf_digit_cell u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl),
            .i_carry (w_carry[g]),
            .o_carry (w_carry[g+1]),
            .o_digit (w_digit[g])
        );
    end

    // Count the digits to show
    always_comb begin
        w_len = CW'(1);
        for (int j = 0; j < NUM_DIGITS; j++) begin
            if (w_digit[j] != 4'd0) begin
                w_len = CW'(j + 1);
            end
        end
        if (r_ovf) begin
            w_len = NDIG;
        end
        if (r_fixed) begin
            if (int'(r_cnt) > NUM_DIGITS) begin
                w_len = NDIG;
            end else begin
                w_len = CW'(r_cnt);
            end
        end
    end

    // Place the current digit or the dash on the display row
    always_comb begin
        if (r_dash_now) begin
            w_pos = NDIG - r_len - CW'(1);
        end else if (r_left) begin
            w_pos = r_len - CW'(1) - CW'(r_dig);
        end else begin
            w_pos = NDIG - CW'(1) - CW'(r_dig);
        end
    end

    // Sequence the request and register the results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (start) begin
                        r_state    <= ST_CONV;
                        r_shreg    <= w_mag;
                        r_bitcnt   <= BW'(VALUE_WIDTH - 1);
                        r_ovf      <= 1'b0;
                        r_fixed    <= (i_opcode == OP_FIXED);
                        r_left     <= i_left_align && (i_opcode != OP_SIGNED);
                        r_neg      <= (i_opcode == OP_SIGNED) && i_value[VALUE_WIDTH-1];
                        r_cnt      <= i_digit_count;
                        r_dash_now <= 1'b0;
                        if (i_opcode == OP_SIGNED || i_radix == RADIX_DEC) begin
                            r_mode <= CELL_DEC;
                        end else if (i_radix == RADIX_BIN) begin
                            r_mode <= CELL_BIN;
                        end else begin
                            r_mode <= CELL_HEX;
                        end
                    end
                end
                ST_CONV: begin
                    r_shreg <= r_shreg << 1;
                    r_ovf   <= r_ovf | w_carry[NUM_DIGITS];
                    if (r_bitcnt == BW'(0)) begin
                        r_state <= ST_LEN;
                    end else begin
                        r_bitcnt <= r_bitcnt - BW'(1);
                    end
                end
                ST_LEN: begin
                    r_len  <= w_len;
                    r_dig  <= IW'(w_len - CW'(1));
                    r_dash <= r_neg && (w_len < NDIG);
                    if (w_len == CW'(0)) begin
                        r_state <= ST_IDLE;
                    end else begin
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    r_strobe <= 1'b1;
                    r_sel    <= ~(NUM_DIGITS'(1) << w_pos);
                    if (r_dash_now) begin
                        r_seg      <= SEG_DASH;
                        r_last     <= 1'b1;
                        r_dash_now <= 1'b0;
                        r_state    <= ST_IDLE;
                    end else begin
                        r_seg  <= seg_of(w_digit[r_dig]);
                        r_last <= (r_dig == IW'(0)) && !r_dash;
                        if (r_dig != IW'(0)) begin
                            r_dig <= r_dig - IW'(1);
                        end else if (r_dash) begin
                            r_dash_now <= 1'b1;
                        end else begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_strobe       = r_strobe;
    assign o_segments     = r_seg;
    assign o_digit_select = r_sel;
    assign o_last         = r_last;

`include "seven_segment_number_formatter_assert.svh"

    `SSNF_ASSERT_NOW(a_sel_one_cold, o_strobe, $onehot(~o_digit_select), "select not one-cold")
    `SSNF_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted request not busy")
    `SSNF_ASSERT_NOW(a_mid_busy, o_strobe && !o_last, busy, "idle before last result")
    `SSNF_ASSERT_NEXT(a_last_gap, o_strobe && o_last, !o_strobe, "result after last")

endmodule

// File: hw/rtl/ssnf_digit_cell.sv
// ----------------------------------------------------------------------------
// ssnf_digit_cell
// One digit of the conversion chain: shift-add-3 in decimal, plain shift in
// hex, single bit in binary. Hands its top bit to the next cell.
// ----------------------------------------------------------------------------
module ssnf_digit_cell
    import ssnf_pkg::*;
(
    input  logic       i_clk,
    input  t_cell_ctrl i_ctrl,
    input  logic       i_carry,
    output logic       o_carry,
    output logic [3:0] o_digit
);

    logic [3:0] r_digit;
    logic [3:0] n_digit;
    logic [3:0] w_adj;

    // Correct a decimal digit of five or more before it doubles
    always_comb begin
        w_adj = r_digit;
        if (r_digit >= 4'd5) begin
            w_adj = r_digit + 4'd3;
        end
    end

    // Form the shifted digit and the bit handed upward
    always_comb begin
        case (i_ctrl.mode)
            CELL_DEC: begin
                o_carry = w_adj[3];
                n_digit = {w_adj[2:0], i_carry};
            end
            CELL_HEX: begin
                o_carry = r_digit[3];
                n_digit = {r_digit[2:0], i_carry};
            end
            default: begin
                o_carry = r_digit[0];
                n_digit = {3'b000, i_carry};
            end
        endcase
    end

    // Hold, clear or advance the digit
    always_ff @(posedge i_clk) begin
        if (i_ctrl.clear) begin
            r_digit <= 4'd0;
        end else if (i_ctrl.shift) begin
            r_digit <= n_digit;
        end
    end

    assign o_digit = r_digit;

endmodule
